FILE: design/kdlp_pkg.sv
package kdlp_pkg;

	localparam int STORE_DEPTH_DEF = 16;
	localparam int FIRST_DIGIT_BIT = 0;
	localparam int NUM_DIGITS      = 10;
	localparam int ENTER_BIT       = 10;
	localparam int CANCEL_BIT      = 11;

	localparam int                KEY_W      = 16;
	localparam int                HOLD_W     = 17;
	localparam logic [HOLD_W-1:0] HOLD_MAX   = '1;
	localparam logic [15:0]       LONG_RESET = 16'd100;

	typedef enum logic [2:0] {
		REQ_TICK       = 3'd0,
		REQ_CLR_ENTER  = 3'd1,
		REQ_CLR_CANCEL = 3'd2,
		REQ_CLR_DIGITS = 3'd3,
		REQ_READ       = 3'd4
	} kdlp_req_t;

	typedef enum logic [1:0] {
		MODE_RELEASED = 2'd0,
		MODE_PRESSING = 2'd1,
		MODE_LONG     = 2'd2
	} kdlp_mode_t;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [KEY_W-1:0] key_bits;
		logic [3:0]       read_index;
	} kdlp_in_t;

	typedef struct packed {
		logic       enter_new_press;
		logic       enter_long;
		logic       cancel_new_press;
		logic       cancel_long;
		logic [3:0] digit_count;
		logic [3:0] read_digit;
	} kdlp_out_t;

	// per-key controls from the sampler to a key machine
	typedef struct packed {
		logic tick;   // stable sample this cycle
		logic held;
		logic fresh;
		logic clear;
	} kdlp_key_ctrl_t;

	typedef struct packed {
		logic new_press;
		logic long_press;
	} kdlp_key_flags_t;

endpackage

FILE: design/kdlp_key_fsm.sv
module kdlp_key_fsm (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kdlp_pkg::kdlp_key_ctrl_t ctrl,
	input  logic [15:0]              threshold,
	output kdlp_pkg::kdlp_key_flags_t flags_next
);
	import kdlp_pkg::*;

	kdlp_mode_t        mode_q, mode_next;
	logic [HOLD_W-1:0] hold_q, hold_next;
	kdlp_key_flags_t   flags_q;
	logic              over_thr;

	always_comb begin
		hold_next = hold_q;
		if (ctrl.tick) begin
			if (!ctrl.held)
				hold_next = '0;
			else if (hold_q != HOLD_MAX)
				hold_next = hold_q + 1'b1;
		end
	end

	assign over_thr = hold_next > HOLD_W'(threshold);

	always_comb begin
		mode_next = mode_q;
		if (ctrl.tick) begin
			unique case (mode_q)
				MODE_RELEASED: begin
					if (ctrl.held)
						mode_next = MODE_PRESSING;
				end
				MODE_PRESSING: begin
					if (!ctrl.held)
						mode_next = MODE_RELEASED;
					else if (over_thr)
						mode_next = MODE_LONG;
				end
				MODE_LONG: begin
					if (!ctrl.held)
						mode_next = MODE_RELEASED;
				end
				default: mode_next = mode_q;
			endcase
		end
	end

	always_comb begin
		flags_next = flags_q;
		if (ctrl.clear) begin
			flags_next = '0;
		end else if (ctrl.tick) begin
			flags_next.new_press  = ctrl.fresh;
			flags_next.long_press = flags_q.long_press
				| (mode_q == MODE_PRESSING && ctrl.held && over_thr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RELEASED;
			hold_q  <= '0;
			flags_q <= '0;
		end else begin
			mode_q  <= mode_next;
			hold_q  <= hold_next;
			flags_q <= flags_next;
		end
	end

endmodule

FILE: design/keypad_debounce_long_press.sv
// Debounced keypad front end. Each request returns exactly one result transaction with the
// status after that request. Throughput is one request per clock while no result is held
// by out_stall; each request passes the input register, then the result register, with a
// single pass of compare, digit pick and hold counter update between them. A held result
// blocks entry once the input register is full. cfg_wr_data sets the long press threshold
// (reset 100); write it only while no transaction is in flight. A tick counts only when
// key_bits equals the previous tick's bitmap; on a stable tick the lowest newly pressed
// digit key is appended to the digit store, whose count wraps at STORE_DEPTH.
module keypad_debounce_long_press #(
	parameter int STORE_DEPTH = kdlp_pkg::STORE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  kdlp_pkg::kdlp_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output kdlp_pkg::kdlp_out_t out_data,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data
);
	import kdlp_pkg::*;

	localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic             valid_s1;
	kdlp_in_t         data_s1;
	logic             out_valid_q;
	kdlp_out_t        out_data_q;
	logic [15:0]      thr_q;
	logic [KEY_W-1:0] raw_prev_q, stable_prev_q;
	logic [3:0]       digit_fill_q, digit_fill_d;
	logic [3:0]       digit_store_q [STORE_DEPTH];

	logic advance, fire;
	logic is_tick, clr_enter, clr_cancel, clr_digits, is_read;
	logic stable_tick;
	logic pick_found;
	logic [3:0] pick_pos;
	logic [3:0] fill_inc;
	logic rd_hit;
	kdlp_key_ctrl_t  enter_ctrl, cancel_ctrl;
	kdlp_key_flags_t enter_flags, cancel_flags;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			data_s1 <= in_data;
	end

	always_comb begin
		is_tick    = 1'b0;
		clr_enter  = 1'b0;
		clr_cancel = 1'b0;
		clr_digits = 1'b0;
		is_read    = 1'b0;
		unique case (data_s1.req_type)
			REQ_TICK:       is_tick    = fire;
			REQ_CLR_ENTER:  clr_enter  = fire;
			REQ_CLR_CANCEL: clr_cancel = fire;
			REQ_CLR_DIGITS: clr_digits = fire;
			REQ_READ:       is_read    = fire;
			default: ;
		endcase
	end

	assign stable_tick = is_tick && (data_s1.key_bits == raw_prev_q);

	// lowest digit key that is down now and was up on the last stable sample
	always_comb begin
		pick_found = 1'b0;
		pick_pos   = '0;
		for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
			if (data_s1.key_bits[FIRST_DIGIT_BIT + k]
			    && !stable_prev_q[FIRST_DIGIT_BIT + k]) begin
				pick_found = 1'b1;
				pick_pos   = 4'(FIRST_DIGIT_BIT + k);
			end
		end
	end

	assign fill_inc = ({1'b0, digit_fill_q} == 5'(STORE_DEPTH - 1)) ? '0 : digit_fill_q + 1'b1;

	always_comb begin
		digit_fill_d = digit_fill_q;
		if (clr_digits)
			digit_fill_d = '0;
		else if (stable_tick && pick_found)
			digit_fill_d = fill_inc;
	end

	// entries at or above the fill count are never read, so the store needs no clear
	assign rd_hit = is_read && (data_s1.read_index < digit_fill_q);

	always_ff @(posedge clk) begin
		if (stable_tick && pick_found)
			digit_store_q[digit_fill_q[IDX_W-1:0]] <= pick_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= LONG_RESET;
			raw_prev_q    <= '0;
			stable_prev_q <= '0;
			digit_fill_q  <= '0;
		end else begin
			if (cfg_wr_en)
				thr_q <= cfg_wr_data;
			if (is_tick)
				raw_prev_q <= data_s1.key_bits;
			if (stable_tick)
				stable_prev_q <= data_s1.key_bits;
			digit_fill_q <= digit_fill_d;
		end
	end

	always_comb begin
		enter_ctrl.tick   = stable_tick;
		enter_ctrl.held   = data_s1.key_bits[ENTER_BIT];
		enter_ctrl.fresh  = data_s1.key_bits[ENTER_BIT] && !stable_prev_q[ENTER_BIT];
		enter_ctrl.clear  = clr_enter;
		cancel_ctrl.tick  = stable_tick;
		cancel_ctrl.held  = data_s1.key_bits[CANCEL_BIT];
		cancel_ctrl.fresh = data_s1.key_bits[CANCEL_BIT] && !stable_prev_q[CANCEL_BIT];
		cancel_ctrl.clear = clr_cancel;
	end

	kdlp_key_fsm u_enter (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (enter_ctrl),
		.threshold  (thr_q),
		.flags_next (enter_flags)
	);

	kdlp_key_fsm u_cancel (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (cancel_ctrl),
		.threshold  (thr_q),
		.flags_next (cancel_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q.enter_new_press  <= enter_flags.new_press;
			out_data_q.enter_long       <= enter_flags.long_press;
			out_data_q.cancel_new_press <= cancel_flags.new_press;
			out_data_q.cancel_long      <= cancel_flags.long_press;
			out_data_q.digit_count      <= digit_fill_d;
			out_data_q.read_digit       <= rd_hit
				? digit_store_q[data_s1.read_index[IDX_W-1:0]] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, digit_fill_q} < 5'(STORE_DEPTH))
		else $error("digit fill count out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !is_read) |=> out_data.read_digit == '0)
		else $error("read_digit nonzero on a non-read transaction");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!fire) |=> $stable(digit_fill_q))
		else $error("digit fill changed without a transaction");

endmodule
